FILE: hdl/trie_word_store_unit_macros.svh
// ----------------------------------------------------------------------------
// Trie word store assertion macros
// Shared concurrent assertion forms for the checker of the trie word store.
// ----------------------------------------------------------------------------
`ifndef TRIE_WORD_STORE_UNIT_MACROS_SVH
`define TRIE_WORD_STORE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TWS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/tws_pkg.sv
// ----------------------------------------------------------------------------
// Trie word store package
// Sizes, action codes and the command and status bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tws_pkg;

   localparam int NODE_COUNT    = 1024;
   localparam int ALPHABET_SIZE = 26;

   localparam int NODE_W   = $clog2(NODE_COUNT);
   localparam int SLOT_W   = $clog2(ALPHABET_SIZE);
   localparam int COUNT_W  = 16;
   localparam int LETTER_W = 5;
   localparam int ACTION_W = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_COUNT  = 2'd2;

   // One row of the child table: the child pointer of every letter of a node.
   typedef logic [ALPHABET_SIZE-1:0][NODE_W-1:0] row_type;

   // Word end flag above the prefix count.
   typedef struct packed {
      logic               word_end;
      logic [COUNT_W-1:0] count;
   } node_type;

   typedef struct packed {
      logic accept;   // take the offered item and launch its row read
      logic resolve;  // row data is back: pick or allocate the child
      logic finish;   // node data is back: write back, post last item's result
      logic clear;    // clearing pass over both memories
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic blocked;   // a last item cannot finish while the result waits
   } status_type;

endpackage

FILE: hdl/tws_control.sv
// ----------------------------------------------------------------------------
// Trie word store controller
// Sequences the clearing pass and the row and node phases of each item.
// ----------------------------------------------------------------------------
module tws_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output tws_pkg::cmd_type    cmd,
   input  tws_pkg::status_type status
);
   import tws_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_ROW   = 4'b0100,
      ST_NODE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      finish;
   logic      accept;

   assign finish    = (state_ff == ST_NODE) && !status.blocked;
   assign req_ready = (state_ff == ST_IDLE) || finish;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.accept  = accept;
      cmd.resolve = (state_ff == ST_ROW);
      cmd.finish  = finish;
      cmd.clear   = (state_ff == ST_CLEAR);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_ROW;
         end
         ST_ROW: begin
            state_in = ST_NODE;
         end
         ST_NODE: begin
            // The next item may enter in the same cycle the current one ends.
            if (accept) state_in = ST_ROW;
            else if (finish) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

endmodule

FILE: hdl/tws_datapath.sv
// ----------------------------------------------------------------------------
// Trie word store datapath
// Child table rows, node counts and word end flags, the walk registers and
// the result register.
// ----------------------------------------------------------------------------
module tws_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [tws_pkg::ACTION_W-1:0]          req_action,
   input  logic [tws_pkg::LETTER_W-1:0]          req_letter,
   input  logic                                  req_has_letter,
   input  logic                                  req_last_letter,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic                                  rsp_found,
   output logic [tws_pkg::COUNT_W-1:0]           rsp_word_count,
   output logic                                  rsp_pool_overflow,
   input  tws_pkg::cmd_type                      cmd,
   output tws_pkg::status_type                   status
);
   import tws_pkg::*;

   row_type  row_mem [NODE_COUNT];
   node_type node_mem [NODE_COUNT];

   row_type  row_rd_ff;
   node_type node_rd_ff;

   logic [NODE_W-1:0]   clr_idx_ff;
   logic [ACTION_W-1:0] item_action_ff;
   logic [LETTER_W-1:0] item_letter_ff;
   logic                item_last_ff;
   logic                step_en_ff;

   logic [NODE_W-1:0]  walk_ff, walk_in;
   logic               missed_ff, missed_in;
   logic               mid_ff, mid_in;
   logic [NODE_W:0]    next_free_ff;
   logic               bump_ff;
   logic [COUNT_W-1:0] root_count_ff;
   logic               root_end_ff;

   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_overflow_ff;

   // Accept phase.
   logic              new_word;
   logic              eff_missed;
   logic [NODE_W-1:0] eff_walk;
   logic              letter_ok;
   logic              step_en_in;

   // Resolve phase.
   logic [SLOT_W-1:0] slot_sel;
   logic [NODE_W-1:0] child;
   logic              is_insert;
   logic              has_room;
   logic              alloc;
   logic              miss;
   logic              advance;
   logic [NODE_W-1:0] target;
   row_type           row_wr;

   // Finish phase.
   logic               at_root;
   node_type           cur;
   logic [COUNT_W-1:0] bumped;
   logic               set_end;
   node_type           node_wr;

   assign new_word   = !mid_ff || (cmd.finish && item_last_ff);
   assign eff_missed = new_word ? 1'b0 : missed_ff;
   assign eff_walk   = new_word ? '0 : walk_ff;
   assign letter_ok  = (32'(req_letter) < ALPHABET_SIZE);
   assign step_en_in = req_has_letter && letter_ok && !eff_missed;

   assign slot_sel  = SLOT_W'(item_letter_ff);
   assign child     = row_rd_ff[slot_sel];
   assign is_insert = (item_action_ff == ACT_INSERT);
   assign has_room  = (next_free_ff < (NODE_W+1)'(NODE_COUNT));
   assign alloc     = step_en_ff && (child == '0) && is_insert && has_room;
   assign miss      = step_en_ff && (child == '0) && !alloc;
   assign advance   = step_en_ff && !miss;
   assign target    = alloc ? NODE_W'(next_free_ff) : (advance ? child : walk_ff);

   always_comb begin
      row_wr           = row_rd_ff;
      row_wr[slot_sel] = NODE_W'(next_free_ff);
   end

   // The root lives in registers, so a word start can bump it at once.
   assign at_root = (walk_ff == '0);
   assign cur     = at_root ? node_type'{word_end: root_end_ff, count: root_count_ff}
                            : node_rd_ff;
   assign bumped  = (bump_ff && (cur.count != COUNT_MAX)) ? cur.count + 1'b1 : cur.count;
   assign set_end = is_insert && item_last_ff && !missed_ff;
   assign node_wr = node_type'{word_end: cur.word_end | set_end, count: bumped};

   always_ff @(posedge clock) begin
      if (cmd.clear) row_mem[clr_idx_ff] <= '0;
      else if (cmd.resolve && alloc) row_mem[walk_ff] <= row_wr;
      if (cmd.accept) row_rd_ff <= row_mem[eff_walk];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) node_mem[clr_idx_ff] <= '0;
      else if (cmd.finish && !at_root) node_mem[walk_ff] <= node_wr;
      if (cmd.resolve) node_rd_ff <= node_mem[target];
   end

   always_comb begin
      walk_in   = walk_ff;
      missed_in = missed_ff;
      mid_in    = mid_ff;
      if (cmd.resolve) begin
         walk_in   = target;
         missed_in = missed_ff | miss;
      end
      if (cmd.finish && item_last_ff) begin
         walk_in   = '0;
         missed_in = 1'b0;
         mid_in    = 1'b0;
      end
      if (cmd.accept) begin
         mid_in = 1'b1;
         if (new_word) begin
            walk_in   = '0;
            missed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff    <= '0;
         walk_ff       <= '0;
         missed_ff     <= 1'b0;
         mid_ff        <= 1'b0;
         next_free_ff  <= (NODE_W+1)'(1);
         root_count_ff <= '0;
         root_end_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.clear) clr_idx_ff <= clr_idx_ff + 1'b1;
         walk_ff   <= walk_in;
         missed_ff <= missed_in;
         mid_ff    <= mid_in;
         if (cmd.resolve && alloc) next_free_ff <= next_free_ff + 1'b1;
         if (cmd.accept && new_word && (req_action == ACT_INSERT) &&
             (root_count_ff != COUNT_MAX)) begin
            root_count_ff <= root_count_ff + 1'b1;
         end
         if (cmd.finish && at_root && set_end) root_end_ff <= 1'b1;
         if (cmd.finish && item_last_ff) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_action_ff <= req_action;
         item_letter_ff <= req_letter;
         item_last_ff   <= req_last_letter;
         step_en_ff     <= step_en_in;
      end
      if (cmd.resolve) bump_ff <= is_insert && advance;
      if (cmd.finish && item_last_ff) begin
         rsp_found_ff    <= (item_action_ff == ACT_SEARCH) && !missed_ff && cur.word_end;
         rsp_count_ff    <= ((item_action_ff == ACT_COUNT) && !missed_ff) ? cur.count : '0;
         rsp_overflow_ff <= is_insert && missed_ff;
      end
   end

   always_comb begin
      status.clear_done = (clr_idx_ff == NODE_W'(NODE_COUNT - 1));
      status.blocked    = item_last_ff && rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_word_count    = rsp_count_ff;
   assign rsp_pool_overflow = rsp_overflow_ff;

endmodule

FILE: hdl/trie_word_store_unit.sv
// ----------------------------------------------------------------------------
// Trie word store unit
// Prefix tree over a letter alphabet with insert, search and prefix count.
// ----------------------------------------------------------------------------
// Words arrive one letter per transaction; the transaction marked last letter
// yields one result. After reset the block runs a clearing pass over all
// NODE_COUNT entries (1024 by default) of the child rows and node memories,
// with req_ready low. Each letter then takes two steps: the first reads the
// node's child row, the second picks or allocates the child and reads that
// child's count and word end; the count write-back overlaps the next
// letter's row read. The root node is kept in registers. A last letter waits
// while a previous result has not yet been taken.
module trie_word_store_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tws_pkg::ACTION_W-1:0]  req_action,
   input  logic [tws_pkg::LETTER_W-1:0]  req_letter,
   input  logic                          req_has_letter,
   input  logic                          req_last_letter,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [tws_pkg::COUNT_W-1:0]   rsp_word_count,
   output logic                          rsp_pool_overflow
);
   import tws_pkg::*;

   cmd_type    cmd;
   status_type status;

   tws_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   tws_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_action),
      .req_letter        (req_letter),
      .req_has_letter    (req_has_letter),
      .req_last_letter   (req_last_letter),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_word_count    (rsp_word_count),
      .rsp_pool_overflow (rsp_pool_overflow),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

FILE: hdl/tws_checker.sv
// ----------------------------------------------------------------------------
// Trie word store checker
// Port-level assertions on the trie word store, bound to the top level.
// ----------------------------------------------------------------------------
`include "trie_word_store_unit_macros.svh"

module tws_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [tws_pkg::ACTION_W-1:0]  req_action,
   input logic [tws_pkg::LETTER_W-1:0]  req_letter,
   input logic                          req_has_letter,
   input logic                          req_last_letter,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_found,
   input logic [tws_pkg::COUNT_W-1:0]   rsp_word_count,
   input logic                          rsp_pool_overflow
);

   // The clearing pass keeps the input closed right after reset.
   `TWS_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, !req_ready,
      "input ready right after reset")

   // Every letter passes through its child row step before the next one enters.
   `TWS_ASSERT_NEXT(a_item_spacing, clock, reset, req_valid && req_ready, !req_ready,
      "two transactions accepted in consecutive cycles")

   // A waiting request keeps its payload until it is taken.
   `TWS_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready,
      req_valid && $stable(req_action) && $stable(req_letter) &&
      $stable(req_has_letter) && $stable(req_last_letter),
      "waiting request changed")

   // A result reports at most one of found, a count and an overflow.
   `TWS_ASSERT_NOW(a_one_result_kind, clock, reset, rsp_valid,
      $countones({rsp_found, rsp_pool_overflow, rsp_word_count != '0}) <= 1,
      "result mixes found, count and overflow")

   `TWS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_found) && $stable(rsp_word_count) &&
      $stable(rsp_pool_overflow),
      "stalled result changed")

endmodule

bind trie_word_store_unit tws_checker u_checker (.*);
